### design/assert_macros.svh
// Assertion macros for the BC1 block decoder top level.
// Depends on nothing; each macro takes the clock and the active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clock, rst_n, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clock, rst_n, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### design/bc1d_pkg.sv
// Types and helper functions for the BC1 block decoder.
// Used by the palette builder and the top level; depends on nothing.
package bc1d_pkg;

	localparam int unsigned PixW = 16;
	localparam int unsigned ChanW = 5;
	localparam int unsigned Side = 4;
	localparam int unsigned RowW = PixW * Side;
	localparam int unsigned CountW = 3;

	localparam logic [PixW-1:0] Transparent = 16'h0000;
	localparam logic [6:0] Recip3 = 7'd43;

	typedef logic [PixW-1:0] pixel_t;
	typedef pixel_t [3:0] palette_t;
	typedef logic [ChanW-1:0] chan_t;

	// Truncating division by three for values below 96, by multiplying with 43/128.
	function automatic chan_t div3(input logic [6:0] x);
		logic [13:0] prod;
		begin
			prod = x * Recip3;
			div3 = prod[11:7];
		end
	endfunction

	function automatic pixel_t pack(input chan_t r, input chan_t g, input chan_t b);
		pack = {r, g, b, 1'b1};
	endfunction

endpackage

### design/bc1d_palette.sv
// Four-entry palette builder for one BC1 block.
// Depends on bc1d_pkg for the pixel types and the division helper.
module bc1d_palette (
	input  bc1d_pkg::pixel_t   endpoint_first,
	input  bc1d_pkg::pixel_t   endpoint_second,
	output bc1d_pkg::palette_t palette
);
	import bc1d_pkg::*;

	chan_t r0, g0, b0, r1, g1, b1;
	logic [6:0] r_mix2, g_mix2, b_mix2, r_mix3, g_mix3, b_mix3;
	logic [5:0] r_sum, g_sum, b_sum;

	assign r0 = endpoint_first[15:11];
	assign g0 = endpoint_first[10:6];
	assign b0 = endpoint_first[5:1];
	assign r1 = endpoint_second[15:11];
	assign g1 = endpoint_second[10:6];
	assign b1 = endpoint_second[5:1];

	assign r_mix2 = {1'b0, r0, 1'b0} + {2'b00, r1};
	assign g_mix2 = {1'b0, g0, 1'b0} + {2'b00, g1};
	assign b_mix2 = {1'b0, b0, 1'b0} + {2'b00, b1};
	assign r_mix3 = {2'b00, r0} + {1'b0, r1, 1'b0};
	assign g_mix3 = {2'b00, g0} + {1'b0, g1, 1'b0};
	assign b_mix3 = {2'b00, b0} + {1'b0, b1, 1'b0};

	assign r_sum = {1'b0, r0} + {1'b0, r1};
	assign g_sum = {1'b0, g0} + {1'b0, g1};
	assign b_sum = {1'b0, b0} + {1'b0, b1};

	always_comb begin
		palette[0] = endpoint_first | pixel_t'(1);
		palette[1] = endpoint_second | pixel_t'(1);
		if (endpoint_first > endpoint_second) begin
			palette[2] = pack(div3(r_mix2), div3(g_mix2), div3(b_mix2));
			palette[3] = pack(div3(r_mix3), div3(g_mix3), div3(b_mix3));
		end else begin
			palette[2] = pack(r_sum[5:1], g_sum[5:1], b_sum[5:1]);
			palette[3] = Transparent;
		end
	end

endmodule

### design/bc1_block_decode_rgba5551.sv
// BC1 block decoder with RGBA5551 output. One compressed block is taken per
// transfer and one decoded block of four row words and a write mask is returned;
// while out_ready is high a new block can be taken in every cycle, so the sustained
// rate is one block per cycle, set by the single register stage on each side of
// the palette and pixel select logic. Pixels outside the valid columns and rows
// read as zero. Depends on bc1d_pkg, bc1d_palette and assert_macros.svh.
`include "assert_macros.svh"

module bc1_block_decode_rgba5551 (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  bc1d_pkg::pixel_t       endpoint_first,
	input  bc1d_pkg::pixel_t       endpoint_second,
	input  logic [31:0]            index_word,
	input  logic [2:0]             cols_valid,
	input  logic [2:0]             rows_valid,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [63:0]            row0_pixels,
	output logic [63:0]            row1_pixels,
	output logic [63:0]            row2_pixels,
	output logic [63:0]            row3_pixels,
	output logic [15:0]            write_mask
);
	import bc1d_pkg::*;

	logic vld_s1;
	logic adv_s1;
	pixel_t ep0_s1, ep1_s1;
	logic [31:0] idx_s1;
	logic [CountW-1:0] cols_s1, rows_s1;

	palette_t palette;
	logic [RowW-1:0] rows_d [Side];
	logic [15:0] mask_d;

	logic [RowW-1:0] rows_s2 [Side];
	logic [15:0] mask_s2;
	logic vld_s2;

	assign adv_s1 = vld_s1 && (!vld_s2 || out_ready);
	assign in_ready = !vld_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ep0_s1 <= endpoint_first;
			ep1_s1 <= endpoint_second;
			idx_s1 <= index_word;
			cols_s1 <= cols_valid;
			rows_s1 <= rows_valid;
		end
	end

	bc1d_palette u_palette (
		.endpoint_first  (ep0_s1),
		.endpoint_second (ep1_s1),
		.palette         (palette)
	);

	always_comb begin
		for (int dy = 0; dy < Side; dy++) begin
			rows_d[dy] = '0;
			for (int dx = 0; dx < Side; dx++) begin
				if ((CountW'(dx) < cols_s1) && (CountW'(dy) < rows_s1)) begin
					rows_d[dy][PixW*dx +: PixW] = palette[idx_s1[2*(Side*dy+dx) +: 2]];
					mask_d[Side*dy+dx] = 1'b1;
				end else begin
					mask_d[Side*dy+dx] = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (!vld_s2 || out_ready) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			rows_s2 <= rows_d;
			mask_s2 <= mask_d;
		end
	end

	assign out_valid = vld_s2;
	assign row0_pixels = rows_s2[0];
	assign row1_pixels = rows_s2[1];
	assign row2_pixels = rows_s2[2];
	assign row3_pixels = rows_s2[3];
	assign write_mask = mask_s2;

	`ASSERT_SAME(a_masked_pixel_zero, clk, arst_n, out_valid && !write_mask[0], row0_pixels[15:0] == 16'h0000)
	`ASSERT_SAME(a_mask_rows_nested, clk, arst_n, out_valid, (write_mask[7:4] & ~write_mask[3:0]) == 4'h0)
	`ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, in_valid && in_ready, vld_s1)
	`ASSERT_NEXT(a_s1_moves_to_out, clk, arst_n, vld_s1 && !out_valid, out_valid)

endmodule

### tb/sv/bc1_block_decode_rgba5551_tb.sv
// Self-checking testbench for the BC1 block decoder with RGBA5551 output.
// Drives compressed blocks through bc1_block_decode_rgba5551 and checks each result
// against an in-bench palette and pixel predictor; depends on bc1d_pkg.
module bc1_block_decode_rgba5551_tb;

	import bc1d_pkg::pixel_t;

	localparam int unsigned CycleLimit = 200000;
	localparam int unsigned ReportLimit = 10;

	typedef struct packed {
		logic [3:0][63:0] rows;
		logic [15:0] mask;
	} decoded_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	pixel_t endpoint_first;
	pixel_t endpoint_second;
	logic [31:0] index_word;
	logic [2:0] cols_valid;
	logic [2:0] rows_valid;
	logic out_valid;
	logic out_ready;
	logic [63:0] row0_pixels;
	logic [63:0] row1_pixels;
	logic [63:0] row2_pixels;
	logic [63:0] row3_pixels;
	logic [15:0] write_mask;

	decoded_t decoded_q [$];
	int unsigned error_count;
	int unsigned cycle_count;
	bit tx_idle_on;
	logic rx_idle_on;
	logic rx_hold;
	int unsigned rx_stall_left;

	bc1_block_decode_rgba5551 i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.endpoint_first(endpoint_first),
		.endpoint_second(endpoint_second),
		.index_word(index_word),
		.cols_valid(cols_valid),
		.rows_valid(rows_valid),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.row0_pixels(row0_pixels),
		.row1_pixels(row1_pixels),
		.row2_pixels(row2_pixels),
		.row3_pixels(row3_pixels),
		.write_mask(write_mask)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic decoded_t decode_block(input pixel_t c0, input pixel_t c1,
			input logic [31:0] idx, input logic [2:0] cols, input logic [2:0] rows);
		decoded_t res;
		pixel_t pal [4];
		logic [4:0] ch0 [3];
		logic [4:0] ch1 [3];
		logic [4:0] mix2 [3];
		logic [4:0] mix3 [3];
		int ncol;
		int nrow;
		int p;
		logic [1:0] sel;
		begin
			res = '0;
			ncol = (cols > 3'd4) ? 4 : int'(cols);
			nrow = (rows > 3'd4) ? 4 : int'(rows);
			for (int c = 0; c < 3; c++) begin
				ch0[c] = c0[11 - 5 * c +: 5];
				ch1[c] = c1[11 - 5 * c +: 5];
				if (c0 > c1) begin
					mix2[c] = 5'((2 * int'(ch0[c]) + int'(ch1[c])) / 3);
					mix3[c] = 5'((int'(ch0[c]) + 2 * int'(ch1[c])) / 3);
				end else begin
					mix2[c] = 5'((int'(ch0[c]) + int'(ch1[c])) / 2);
					mix3[c] = '0;
				end
			end
			pal[0] = c0 | 16'h0001;
			pal[1] = c1 | 16'h0001;
			pal[2] = {mix2[0], mix2[1], mix2[2], 1'b1};
			pal[3] = (c0 > c1) ? {mix3[0], mix3[1], mix3[2], 1'b1} : 16'h0000;
			for (int dy = 0; dy < 4; dy++) begin
				for (int dx = 0; dx < 4; dx++) begin
					if (dx < ncol && dy < nrow) begin
						p = 4 * dy + dx;
						sel = idx[2 * p +: 2];
						res.rows[dy][16 * dx +: 16] = pal[sel];
						res.mask[p] = 1'b1;
					end
				end
			end
			decode_block = res;
		end
	endfunction

	// The caller must be at a rising edge; valid is kept high across back-to-back blocks.
	task automatic send_block(input pixel_t c0, input pixel_t c1, input logic [31:0] idx,
			input logic [2:0] cols, input logic [2:0] rows);
		begin
			if (tx_idle_on && $urandom_range(0, 3) == 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end
			in_valid <= 1'b1;
			endpoint_first <= c0;
			endpoint_second <= c1;
			index_word <= idx;
			cols_valid <= cols;
			rows_valid <= rows;
			do @(posedge clk); while (!in_ready);
			decoded_q.push_back(decode_block(c0, c1, idx, cols, rows));
		end
	endtask

	task automatic send_random_block();
		pixel_t c0;
		pixel_t c1;
		logic [2:0] cols;
		logic [2:0] rows;
		begin
			c0 = pixel_t'($urandom);
			case ($urandom_range(0, 9))
				0: c1 = c0;
				1: c1 = c0 ^ 16'h0001;
				default: c1 = pixel_t'($urandom);
			endcase
			cols = 3'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4));
			rows = 3'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4));
			send_block(c0, c1, $urandom, cols, rows);
		end
	endtask

	task automatic test_endpoint_order();
		begin
			send_block(16'hFFFF, 16'h0000, 32'hE4E4E4E4, 3'd4, 3'd4);
			send_block(16'h0000, 16'hFFFF, 32'hE4E4E4E4, 3'd4, 3'd4);
			send_block(16'h1234, 16'h1234, 32'h1B1B1B1B, 3'd4, 3'd4);
			send_block(16'h0001, 16'h0000, 32'hE4E4E4E4, 3'd4, 3'd4);
			send_block(16'h0000, 16'h0001, 32'hE4E4E4E4, 3'd4, 3'd4);
			send_block(16'hF800, 16'h07FE, 32'h9C6B39D2, 3'd4, 3'd4);
			send_block(16'h07C0, 16'h003E, 32'h4E4E4E4E, 3'd4, 3'd4);
			send_block(16'hFFFE, 16'hFFFF, 32'hB1B1B1B1, 3'd4, 3'd4);
		end
	endtask

	task automatic test_index_patterns();
		begin
			send_block(16'hA5F2, 16'h3C19, 32'h00000000, 3'd4, 3'd4);
			send_block(16'hA5F2, 16'h3C19, 32'h55555555, 3'd4, 3'd4);
			send_block(16'hA5F2, 16'h3C19, 32'hAAAAAAAA, 3'd4, 3'd4);
			send_block(16'hA5F2, 16'h3C19, 32'hFFFFFFFF, 3'd4, 3'd4);
			send_block(16'h3C19, 16'hA5F2, 32'hFFFFFFFF, 3'd4, 3'd4);
		end
	endtask

	task automatic test_tile_bounds();
		begin
			send_block(16'hFFFF, 16'h0000, 32'hFFFFFFFF, 3'd0, 3'd4);
			send_block(16'hFFFF, 16'h0000, 32'hFFFFFFFF, 3'd4, 3'd0);
			send_block(16'h8421, 16'h1248, 32'h12345678, 3'd1, 3'd1);
			send_block(16'h8421, 16'h1248, 32'h87654321, 3'd2, 3'd3);
			send_block(16'h1248, 16'h8421, 32'hDEADBEEF, 3'd3, 3'd2);
			send_block(16'h7BDE, 16'h4210, 32'hC3A5965A, 3'd5, 3'd4);
			send_block(16'h4210, 16'h7BDE, 32'h0F0FF0F0, 3'd4, 3'd7);
			send_block(16'hFFFF, 16'hFFFE, 32'hE4E4E4E4, 3'd7, 3'd7);
			send_block(16'h0000, 16'h0000, 32'h3333CCCC, 3'd6, 3'd1);
		end
	endtask

	task automatic test_random_blocks();
		begin
			repeat (420) send_random_block();
		end
	endtask

	task automatic test_output_backpressure();
		begin
			tx_idle_on = 1'b0;
			fork
				begin
					rx_hold <= 1'b1;
					repeat (150) @(posedge clk);
					rx_hold <= 1'b0;
				end
				repeat (40) send_random_block();
			join
			tx_idle_on = 1'b1;
		end
	endtask

	task automatic test_full_rate_stream();
		begin
			tx_idle_on = 1'b0;
			rx_idle_on <= 1'b0;
			repeat (120) send_random_block();
			in_valid <= 1'b0;
		end
	endtask

	always @(posedge clk) begin
		if (rx_hold) begin
			out_ready <= 1'b0;
		end else if (rx_stall_left != 0) begin
			out_ready <= 1'b0;
			rx_stall_left <= rx_stall_left - 1;
		end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
			out_ready <= 1'b0;
			rx_stall_left <= $urandom_range(0, 10);
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin : check_results
		decoded_t want;
		logic [3:0][63:0] got_rows;
		if (arst_n && out_valid && out_ready) begin
			got_rows = {row3_pixels, row2_pixels, row1_pixels, row0_pixels};
			if (decoded_q.size() == 0) begin
				if (error_count < ReportLimit)
					$display("Result transfer with no block pending: mask %h", write_mask);
				error_count++;
			end else begin
				want = decoded_q.pop_front();
				for (int r = 0; r < 4; r++) begin
					if (got_rows[r] !== want.rows[r]) begin
						if (error_count < ReportLimit)
							$display("row%0d_pixels: expected %h, got %h", r, want.rows[r],
								got_rows[r]);
						error_count++;
					end
				end
				if (write_mask !== want.mask) begin
					if (error_count < ReportLimit)
						$display("write_mask: expected %h, got %h", want.mask, write_mask);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CycleLimit) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		endpoint_first <= '0;
		endpoint_second <= '0;
		index_word <= '0;
		cols_valid <= '0;
		rows_valid <= '0;
		out_ready <= 1'b0;
		rx_idle_on <= 1'b1;
		rx_hold <= 1'b0;
		rx_stall_left = 0;
		tx_idle_on = 1'b1;
		error_count = 0;
		cycle_count = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_endpoint_order();
		test_index_patterns();
		test_tile_bounds();
		test_random_blocks();
		test_output_backpressure();
		test_full_rate_stream();
		while (decoded_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

### files.f
+incdir+design
design/bc1d_pkg.sv
design/bc1d_palette.sv
design/bc1_block_decode_rgba5551.sv
tb/sv/bc1_block_decode_rgba5551_tb.sv
